### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on i_clk and
// held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TLTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tltc assertion failed");

// Implication checked on the following clock edge.
`define TLTC_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("tltc assertion failed");

`endif

### sv/tltc_pkg.sv
package tltc_pkg;

    localparam int COUNT_WIDTH_DEF   = 24;
    localparam int CURRENT_WIDTH_DEF = 12;
    localparam int DRIVE_WIDTH       = 16;
    localparam int CFG_IDX_WIDTH     = 3;

    localparam int DOWN_TIME_LIMIT_RST = 50;
    localparam int UP_TIME_LIMIT_RST   = 50;
    localparam int CURRENT_THRESH_RST  = 2048;
    localparam int OC_TIME_LIMIT_RST   = 10;
    localparam logic signed [DRIVE_WIDTH-1:0] DOWN_DRIVE_RST = 16'shC000;
    localparam logic signed [DRIVE_WIDTH-1:0] UP_DRIVE_RST   = 16'sh4000;

    typedef logic [CFG_IDX_WIDTH-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DOWN_TIME_LIMIT = 3'd0;
    localparam t_cfg_idx CFG_UP_TIME_LIMIT   = 3'd1;
    localparam t_cfg_idx CFG_CURRENT_THRESH  = 3'd2;
    localparam t_cfg_idx CFG_OC_TIME_LIMIT   = 3'd3;
    localparam t_cfg_idx CFG_DOWN_DRIVE      = 3'd4;
    localparam t_cfg_idx CFG_UP_DRIVE        = 3'd5;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_DOWN = 2'd1,
        REQ_UP   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        MODE_STILL = 2'd0,
        MODE_DOWN  = 2'd1,
        MODE_UP    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PLACE_TOP    = 2'd0,
        PLACE_BOTTOM = 2'd1,
        PLACE_MOVING = 2'd2
    } t_place;

    typedef struct packed {
        t_mode  mode;
        t_place place;
    } t_ctrl;

    typedef struct packed {
        logic signed [DRIVE_WIDTH-1:0] motor_drive;
        logic                          at_top;
        logic                          at_bottom;
        t_mode                         move_mode;
    } t_result;

endpackage

### sv/tltc_cfg.sv
module tltc_cfg
    import tltc_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
    parameter int CURRENT_WIDTH = CURRENT_WIDTH_DEF,
    parameter int CFG_WIDTH     = (COUNT_WIDTH > DRIVE_WIDTH) ? COUNT_WIDTH : DRIVE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  t_cfg_idx                      i_idx,
    input  logic [CFG_WIDTH-1:0]          i_data,
    output logic [COUNT_WIDTH-1:0]        o_down_time_limit,
    output logic [COUNT_WIDTH-1:0]        o_up_time_limit,
    output logic [CURRENT_WIDTH-1:0]      o_current_threshold,
    output logic [COUNT_WIDTH-1:0]        o_oc_time_limit,
    output logic signed [DRIVE_WIDTH-1:0] o_down_drive,
    output logic signed [DRIVE_WIDTH-1:0] o_up_drive
);

    logic [COUNT_WIDTH-1:0]        r_down_time_limit;
    logic [COUNT_WIDTH-1:0]        r_up_time_limit;
    logic [CURRENT_WIDTH-1:0]      r_current_threshold;
    logic [COUNT_WIDTH-1:0]        r_oc_time_limit;
    logic signed [DRIVE_WIDTH-1:0] r_down_drive;
    logic signed [DRIVE_WIDTH-1:0] r_up_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_time_limit   <= COUNT_WIDTH'(DOWN_TIME_LIMIT_RST);
            r_up_time_limit     <= COUNT_WIDTH'(UP_TIME_LIMIT_RST);
            r_current_threshold <= CURRENT_WIDTH'(CURRENT_THRESH_RST);
            r_oc_time_limit     <= COUNT_WIDTH'(OC_TIME_LIMIT_RST);
            r_down_drive        <= DOWN_DRIVE_RST;
            r_up_drive          <= UP_DRIVE_RST;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_DOWN_TIME_LIMIT: r_down_time_limit   <= i_data[COUNT_WIDTH-1:0];
                CFG_UP_TIME_LIMIT:   r_up_time_limit     <= i_data[COUNT_WIDTH-1:0];
                CFG_CURRENT_THRESH:  r_current_threshold <= i_data[CURRENT_WIDTH-1:0];
                CFG_OC_TIME_LIMIT:   r_oc_time_limit     <= i_data[COUNT_WIDTH-1:0];
                CFG_DOWN_DRIVE:      r_down_drive        <= i_data[DRIVE_WIDTH-1:0];
                CFG_UP_DRIVE:        r_up_drive          <= i_data[DRIVE_WIDTH-1:0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    assign o_down_time_limit   = r_down_time_limit;
    assign o_up_time_limit     = r_up_time_limit;
    assign o_current_threshold = r_current_threshold;
    assign o_oc_time_limit     = r_oc_time_limit;
    assign o_down_drive        = r_down_drive;
    assign o_up_drive          = r_up_drive;

endmodule

### sv/tltc_next.sv
module tltc_next
    import tltc_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
    parameter int CURRENT_WIDTH = CURRENT_WIDTH_DEF
) (
    input  t_req                          i_req,
    input  logic [CURRENT_WIDTH-1:0]      i_current,
    input  logic                          i_switch_n,
    input  t_ctrl                         i_ctrl,
    input  logic [COUNT_WIDTH-1:0]        i_travel,
    input  logic [COUNT_WIDTH-1:0]        i_oc,
    input  logic signed [DRIVE_WIDTH-1:0] i_drive,
    input  logic [COUNT_WIDTH-1:0]        i_down_time_limit,
    input  logic [COUNT_WIDTH-1:0]        i_up_time_limit,
    input  logic [CURRENT_WIDTH-1:0]      i_current_threshold,
    input  logic [COUNT_WIDTH-1:0]        i_oc_time_limit,
    input  logic signed [DRIVE_WIDTH-1:0] i_down_drive,
    input  logic signed [DRIVE_WIDTH-1:0] i_up_drive,
    output t_ctrl                         o_ctrl,
    output logic [COUNT_WIDTH-1:0]        o_travel,
    output logic [COUNT_WIDTH-1:0]        o_oc,
    output logic signed [DRIVE_WIDTH-1:0] o_drive
);

    logic [COUNT_WIDTH-1:0] travel_inc;
    logic [COUNT_WIDTH-1:0] oc_inc;
    logic [COUNT_WIDTH-1:0] oc_cmp;
    logic                   oc_active;

    // saturating increments
    assign travel_inc = (&i_travel) ? i_travel : i_travel + COUNT_WIDTH'(1);
    assign oc_inc     = (&i_oc) ? i_oc : i_oc + COUNT_WIDTH'(1);
    assign oc_active  = (i_ctrl.mode != MODE_STILL) && (i_current > i_current_threshold);
    assign oc_cmp     = oc_active ? i_oc : '0;

    always_comb begin
        o_ctrl   = i_ctrl;
        o_travel = i_travel;
        o_oc     = i_oc;
        o_drive  = i_drive;
        unique case (i_req)
            REQ_TICK: begin
                o_oc = oc_active ? oc_inc : '0;
                unique case (i_ctrl.mode)
                    MODE_DOWN: begin
                        if (i_ctrl.place == PLACE_BOTTOM) begin
                            o_ctrl.mode = MODE_STILL;
                        end else begin
                            if (i_switch_n && (i_travel < i_down_time_limit)) begin
                                o_drive       = i_down_drive;
                                o_ctrl.place  = PLACE_MOVING;
                            end else begin
                                o_drive       = '0;
                                o_ctrl.mode   = MODE_STILL;
                                o_ctrl.place  = PLACE_BOTTOM;
                            end
                            o_travel = travel_inc;
                        end
                    end
                    MODE_UP: begin
                        if (i_ctrl.place == PLACE_TOP) begin
                            o_ctrl.mode = MODE_STILL;
                        end else begin
                            if ((oc_cmp < i_oc_time_limit) && (i_travel < i_up_time_limit)) begin
                                o_drive       = i_up_drive;
                                o_ctrl.place  = PLACE_MOVING;
                            end else begin
                                o_drive       = '0;
                                o_ctrl.mode   = MODE_STILL;
                                o_ctrl.place  = PLACE_TOP;
                            end
                            o_travel = travel_inc;
                        end
                    end
                    default: begin
                        o_drive  = '0;
                        o_travel = '0;
                    end
                endcase
            end
            REQ_DOWN: begin
                if (i_ctrl.mode != MODE_DOWN) begin
                    o_ctrl.mode = MODE_DOWN;
                    o_travel    = '0;
                end
            end
            REQ_UP: begin
                if (i_ctrl.mode != MODE_UP) begin
                    o_ctrl.mode = MODE_UP;
                    o_travel    = '0;
                end
            end
            default: ;  // unused code reports the present state
        endcase
    end

endmodule

### sv/tltc_out.sv
module tltc_out
    import tltc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_full
);

`include "assert_macros.svh"

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    take;

    assign take = r_out_valid && !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
                n_out       = i_result;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_full   = r_skid_valid;

    `TLTC_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid)
    `TLTC_ASSERT_NEXT(a_stalled_push_skids, r_out_valid && i_stall && i_push, r_skid_valid)
    `TLTC_ASSERT_NEXT(a_skid_drains, r_skid_valid && !i_stall, !r_skid_valid && r_out_valid)

endmodule

### sv/timed_limit_travel_controller_core.sv
// Timed limit travel controller: drives a motor toward the top or bottom end.
// Input channel (i_valid / o_stall): one beat carries a tick (i_req_type 0),
// a move-down command (1) or a move-up command (2); code 3 changes nothing.
// Ticks sample i_motor_current and the active-low i_bottom_switch_n.
// Output channel (o_valid / i_stall): exactly one result beat per input beat,
// in order: the applied drive, at_top / at_bottom and the current move mode.
// A beat moves when valid is high and stall is low at a rising i_clk edge.
// The result is registered in the output register before o_valid shows it.
// Throughput is one beat per cycle while o_stall is low; the state update is
// a single pass of next-state logic with counter compares and saturating
// increments. When the receiver stalls, the next beat lands in a one-entry
// skid register and o_stall rises only once that skid register is occupied.
// Configuration uses i_cfg_we / i_cfg_idx / i_cfg_data, to be written by the
// user only while idle; the block does not enforce this. Synchronous reset
// (i_rst_n low) restores the register defaults, sets the position to top,
// mode stationary, drive and counters zero, and empties the output side.
module timed_limit_travel_controller_core
    import tltc_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF,
    parameter int CURRENT_WIDTH = CURRENT_WIDTH_DEF,
    parameter int CFG_WIDTH     = (COUNT_WIDTH > DRIVE_WIDTH) ? COUNT_WIDTH : DRIVE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]      i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]          i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_req_type,
    input  logic [CURRENT_WIDTH-1:0]      i_motor_current,
    input  logic                          i_bottom_switch_n,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [DRIVE_WIDTH-1:0] o_motor_drive,
    output logic                          o_at_top,
    output logic                          o_at_bottom,
    output logic [1:0]                    o_move_mode
);

`include "assert_macros.svh"

    // configuration registers
    logic [COUNT_WIDTH-1:0]        down_time_limit;
    logic [COUNT_WIDTH-1:0]        up_time_limit;
    logic [CURRENT_WIDTH-1:0]      current_threshold;
    logic [COUNT_WIDTH-1:0]        oc_time_limit;
    logic signed [DRIVE_WIDTH-1:0] down_drive;
    logic signed [DRIVE_WIDTH-1:0] up_drive;

    // controller state
    t_ctrl                         r_ctrl;
    t_ctrl                         n_ctrl;
    logic [COUNT_WIDTH-1:0]        r_travel;
    logic [COUNT_WIDTH-1:0]        n_travel;
    logic [COUNT_WIDTH-1:0]        r_oc;
    logic [COUNT_WIDTH-1:0]        n_oc;
    logic signed [DRIVE_WIDTH-1:0] r_drive;
    logic signed [DRIVE_WIDTH-1:0] n_drive;

    logic    in_accept;
    logic    skid_full;
    t_result result;
    t_result out_result;

    assign in_accept = i_valid && !skid_full;
    assign o_stall   = skid_full;

    tltc_cfg #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .CURRENT_WIDTH (CURRENT_WIDTH),
        .CFG_WIDTH     (CFG_WIDTH)
    ) u_cfg (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_we                (i_cfg_we),
        .i_idx               (i_cfg_idx),
        .i_data              (i_cfg_data),
        .o_down_time_limit   (down_time_limit),
        .o_up_time_limit     (up_time_limit),
        .o_current_threshold (current_threshold),
        .o_oc_time_limit     (oc_time_limit),
        .o_down_drive        (down_drive),
        .o_up_drive          (up_drive)
    );

    tltc_next #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .CURRENT_WIDTH (CURRENT_WIDTH)
    ) u_next (
        .i_req               (t_req'(i_req_type)),
        .i_current           (i_motor_current),
        .i_switch_n          (i_bottom_switch_n),
        .i_ctrl              (r_ctrl),
        .i_travel            (r_travel),
        .i_oc                (r_oc),
        .i_drive             (r_drive),
        .i_down_time_limit   (down_time_limit),
        .i_up_time_limit     (up_time_limit),
        .i_current_threshold (current_threshold),
        .i_oc_time_limit     (oc_time_limit),
        .i_down_drive        (down_drive),
        .i_up_drive          (up_drive),
        .o_ctrl              (n_ctrl),
        .o_travel            (n_travel),
        .o_oc                (n_oc),
        .o_drive             (n_drive)
    );

    // advance the state only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '{mode: MODE_STILL, place: PLACE_TOP};
            r_travel <= '0;
            r_oc     <= '0;
            r_drive  <= '0;
        end else if (in_accept) begin
            r_ctrl   <= n_ctrl;
            r_travel <= n_travel;
            r_oc     <= n_oc;
            r_drive  <= n_drive;
        end
    end

    // result reflects the state after this beat is applied
    always_comb begin
        result.motor_drive = n_drive;
        result.at_top      = (n_ctrl.place == PLACE_TOP);
        result.at_bottom   = (n_ctrl.place == PLACE_BOTTOM);
        result.move_mode   = n_ctrl.mode;
    end

    tltc_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_result (result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (out_result),
        .o_full   (skid_full)
    );

    assign o_motor_drive = out_result.motor_drive;
    assign o_at_top      = out_result.at_top;
    assign o_at_bottom   = out_result.at_bottom;
    assign o_move_mode   = out_result.move_mode;

    // travel between ends only happens with a move in progress
    `TLTC_ASSERT(a_moving_has_mode, (r_ctrl.place == PLACE_MOVING) |-> (r_ctrl.mode != MODE_STILL))
    // a tick while stationary drops the drive
    `TLTC_ASSERT_NEXT(a_still_tick_zero,
        in_accept && (i_req_type == REQ_TICK) && (r_ctrl.mode == MODE_STILL), r_drive == '0)
    // a repeated command keeps the travel count running
    `TLTC_ASSERT_NEXT(a_repeat_keeps_travel,
        in_accept && (i_req_type == REQ_DOWN) && (r_ctrl.mode == MODE_DOWN),
        r_travel == $past(r_travel))

endmodule

### dv/tb.sv
module tb;
    import tltc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Request code outside the defined set: the block must leave its state alone.
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_TOP = '1;

    typedef struct {
        logic [1:0]                   req;
        logic [CURRENT_WIDTH_DEF-1:0] current;
        logic                         switch_n;
    } t_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx = '0;
    logic [COUNT_WIDTH_DEF-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_req_type = '0;
    logic [CURRENT_WIDTH_DEF-1:0] i_motor_current = '0;
    logic i_bottom_switch_n = 1'b1;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [DRIVE_WIDTH-1:0] o_motor_drive;
    logic o_at_top;
    logic o_at_bottom;
    logic [1:0] o_move_mode;

    timed_limit_travel_controller_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_motor_current  (i_motor_current),
        .i_bottom_switch_n(i_bottom_switch_n),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_motor_drive    (o_motor_drive),
        .o_at_top         (o_at_top),
        .o_at_bottom      (o_at_bottom),
        .o_move_mode      (o_move_mode)
    );

    // Register copies, kept in step with every write on the config port.
    logic [COUNT_WIDTH_DEF-1:0]   cfg_down_limit = COUNT_WIDTH_DEF'(DOWN_TIME_LIMIT_RST);
    logic [COUNT_WIDTH_DEF-1:0]   cfg_up_limit   = COUNT_WIDTH_DEF'(UP_TIME_LIMIT_RST);
    logic [CURRENT_WIDTH_DEF-1:0] cfg_thresh     = CURRENT_WIDTH_DEF'(CURRENT_THRESH_RST);
    logic [COUNT_WIDTH_DEF-1:0]   cfg_oc_limit   = COUNT_WIDTH_DEF'(OC_TIME_LIMIT_RST);
    logic signed [DRIVE_WIDTH-1:0] cfg_down_drive = DOWN_DRIVE_RST;
    logic signed [DRIVE_WIDTH-1:0] cfg_up_drive   = UP_DRIVE_RST;

    // Controller state as the predictor sees it.
    t_mode  ctl_mode = MODE_STILL;
    t_place ctl_place = PLACE_TOP;
    logic [COUNT_WIDTH_DEF-1:0] travel_ticks = '0;
    logic [COUNT_WIDTH_DEF-1:0] oc_ticks = '0;
    logic signed [DRIVE_WIDTH-1:0] drive_hold = '0;

    t_beat   beats_to_send[$];
    t_result status_due[$];
    t_beat   offered;
    int      gap_pct = 0;
    int      stall_pct = 0;
    bit      pressure_on = 1'b0;
    int      hold_count = 0;
    int      fail_count = 0;

    // Free-running clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [COUNT_WIDTH_DEF-1:0] bump(input logic [COUNT_WIDTH_DEF-1:0] v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    // Apply one beat to the predicted controller and return the status it reports.
    // Counters are compared with their value from before the tick, then bumped.
    function automatic t_result advance_controller(input t_beat b);
        logic [COUNT_WIDTH_DEF-1:0] oc_seen;
        t_result r;
        if (b.req == REQ_TICK) begin
            // Accumulate overcurrent only while moving; otherwise clear it.
            if (ctl_mode != MODE_STILL && b.current > cfg_thresh) begin
                oc_seen = oc_ticks;
                oc_ticks = bump(oc_ticks);
            end else begin
                oc_seen = '0;
                oc_ticks = '0;
            end
            case (ctl_mode)
                MODE_DOWN: begin
                    // Already at the bottom: drop to stationary, keep drive and travel counter.
                    if (ctl_place == PLACE_BOTTOM) begin
                        ctl_mode = MODE_STILL;
                    end else begin
                        if (b.switch_n && travel_ticks < cfg_down_limit) begin
                            drive_hold = cfg_down_drive;
                            ctl_place = PLACE_MOVING;
                        end else begin
                            drive_hold = '0;
                            ctl_mode = MODE_STILL;
                            ctl_place = PLACE_BOTTOM;
                        end
                        travel_ticks = bump(travel_ticks);
                    end
                end
                MODE_UP: begin
                    if (ctl_place == PLACE_TOP) begin
                        ctl_mode = MODE_STILL;
                    end else begin
                        if (oc_seen < cfg_oc_limit && travel_ticks < cfg_up_limit) begin
                            drive_hold = cfg_up_drive;
                            ctl_place = PLACE_MOVING;
                        end else begin
                            drive_hold = '0;
                            ctl_mode = MODE_STILL;
                            ctl_place = PLACE_TOP;
                        end
                        travel_ticks = bump(travel_ticks);
                    end
                end
                default: begin
                    drive_hold = '0;
                    travel_ticks = '0;
                end
            endcase
        end else if (b.req == REQ_DOWN) begin
            // A repeated command keeps the travel counter running.
            if (ctl_mode != MODE_DOWN) begin
                ctl_mode = MODE_DOWN;
                travel_ticks = '0;
            end
        end else if (b.req == REQ_UP) begin
            if (ctl_mode != MODE_UP) begin
                ctl_mode = MODE_UP;
                travel_ticks = '0;
            end
        end
        r.motor_drive = drive_hold;
        r.at_top = (ctl_place == PLACE_TOP);
        r.at_bottom = (ctl_place == PLACE_BOTTOM);
        r.move_mode = ctl_mode;
        return r;
    endfunction

    // Driver: hold the offered beat until it moves, then pull the next one from
    // the pending queue or go idle, as the gap rate decides.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                status_due.push_back(advance_controller(offered));
            end
            if (!i_valid || !o_stall) begin
                if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    offered = beats_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_req_type <= offered.req;
                    i_motor_current <= offered.current;
                    i_bottom_switch_n <= offered.switch_n;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: during a pressure phase hold off for a long stretch first,
    // so the skid register fills and the input side stalls; otherwise stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_count <= 0;
        end else if (pressure_on && hold_count < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
            if (!pressure_on) begin
                hold_count <= 0;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: compare every accepted result beat with the oldest predicted status.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (status_due.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual drive %0d mode %0d",
                         $time, o_motor_drive, o_move_mode);
                fail_count++;
            end else begin
                want = status_due.pop_front();
                check_field("motor_drive", $signed(want.motor_drive), $signed(o_motor_drive));
                check_field("at_top", want.at_top, o_at_top);
                check_field("at_bottom", want.at_bottom, o_at_bottom);
                check_field("move_mode", want.move_mode, o_move_mode);
            end
        end
    end

    task automatic push_beat(input logic [1:0] req, input int current, input logic switch_n);
        t_beat b;
        b.req = req;
        b.current = CURRENT_WIDTH_DEF'(current);
        b.switch_n = switch_n;
        beats_to_send.push_back(b);
    endtask

    // Wait until nothing is queued, offered or owed, then let the pipe settle.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (beats_to_send.size() != 0 || i_valid || status_due.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    // Write all six registers back to back; upper data bits of the threshold
    // and drive writes carry junk to confirm the block masks them off.
    task automatic configure(input logic [COUNT_WIDTH_DEF-1:0] d_lim, u_lim,
                             input logic [CURRENT_WIDTH_DEF-1:0] thr,
                             input logic [COUNT_WIDTH_DEF-1:0] oc_lim,
                             input logic [DRIVE_WIDTH-1:0] d_drv, u_drv);
        logic [COUNT_WIDTH_DEF-1:0] vals [6];
        vals[0] = d_lim;
        vals[1] = u_lim;
        vals[2] = {12'($urandom), thr};
        vals[3] = oc_lim;
        vals[4] = {8'($urandom), d_drv};
        vals[5] = {8'($urandom), u_drv};
        for (int k = 0; k < 6; k++) begin
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_cfg_idx'(k);
            i_cfg_data <= vals[k];
            case (t_cfg_idx'(k))
                CFG_DOWN_TIME_LIMIT: cfg_down_limit = vals[k];
                CFG_UP_TIME_LIMIT:   cfg_up_limit = vals[k];
                CFG_CURRENT_THRESH:  cfg_thresh = vals[k][CURRENT_WIDTH_DEF-1:0];
                CFG_OC_TIME_LIMIT:   cfg_oc_limit = vals[k];
                CFG_DOWN_DRIVE:      cfg_down_drive = vals[k][DRIVE_WIDTH-1:0];
                CFG_UP_DRIVE:        cfg_up_drive = vals[k][DRIVE_WIDTH-1:0];
                default: ;
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Queue random traffic: mostly a move command followed by a run of ticks that
    // may reach the time limit, with repeats and switch presses mixed in;
    // the rest is noise over the whole field range, unused code included.
    task automatic add_random(input int count);
        int made;
        int lim;
        int run;
        logic [1:0] cmd;
        bit heavy;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) < 8) begin
                cmd = $urandom_range(0, 1) ? REQ_DOWN : REQ_UP;
                lim = (cmd == REQ_DOWN) ? int'(cfg_down_limit) : int'(cfg_up_limit);
                if (lim > 40) lim = 40;
                run = $urandom_range(1, lim + 3);
                heavy = 1'($urandom_range(0, 1));
                push_beat(cmd, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
                made++;
                for (int t = 0; t < run; t++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        push_beat(cmd, $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
                        made++;
                    end
                    push_beat(REQ_TICK,
                              heavy ? $urandom_range(cfg_thresh, 4095)
                                    : $urandom_range(0, cfg_thresh),
                              $urandom_range(0, 9) != 0);
                    made++;
                end
            end else begin
                push_beat(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
                          1'($urandom_range(0, 1)));
                made++;
            end
        end
    endtask

    task automatic run_phase(input int gap, input int stall, input int count);
        gap_pct = gap;
        stall_pct = stall;
        add_random(count);
        wait_idle();
    endtask

    // Run limit: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        // Hold reset, then release it for good.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Traffic at the reset values of the registers.
        run_phase(0, 0, 80);

        // Directed: short limits and the drive extremes.
        configure(24'd3, 24'd3, 12'd100, 24'd2, 16'h8000, 16'h7FFF);
        push_beat(REQ_TICK, 0, 1'b1);        // idle tick: drive zero
        push_beat(REQ_NONE, 4095, 1'b0);     // unused code: no change
        push_beat(REQ_UP, 0, 1'b1);          // move up while already at top
        push_beat(REQ_TICK, 4095, 1'b1);     // already at target: stop
        push_beat(REQ_DOWN, 0, 1'b1);
        push_beat(REQ_TICK, 4095, 1'b1);
        push_beat(REQ_DOWN, 0, 1'b1);        // repeated command: counter keeps running
        push_beat(REQ_TICK, 0, 1'b1);
        push_beat(REQ_TICK, 0, 1'b1);
        push_beat(REQ_TICK, 0, 1'b1);        // travel timeout: reach bottom
        push_beat(REQ_DOWN, 0, 1'b1);
        push_beat(REQ_TICK, 0, 1'b0);        // already at bottom
        push_beat(REQ_UP, 0, 1'b1);
        push_beat(REQ_TICK, 4095, 1'b1);
        push_beat(REQ_TICK, 4095, 1'b1);
        push_beat(REQ_TICK, 4095, 1'b1);     // overcurrent limit: reach top
        push_beat(REQ_DOWN, 0, 1'b1);
        push_beat(REQ_TICK, 100, 1'b1);      // current equal to threshold
        push_beat(REQ_TICK, 101, 1'b0);      // bottom switch pressed
        push_beat(REQ_UP, 0, 1'b1);
        push_beat(REQ_TICK, 100, 1'b1);
        push_beat(REQ_DOWN, 0, 1'b1);        // reverse mid-travel: restart counter
        push_beat(REQ_TICK, 0, 1'b1);
        push_beat(REQ_NONE, 0, 1'b1);
        push_beat(REQ_TICK, 4095, 1'b1);
        wait_idle();

        // Random phases through several register settings and idling patterns.
        configure(24'd5, 24'd7, 12'd2048, 24'd3, 16'($urandom), 16'($urandom));
        run_phase(0, 0, 250);

        configure(24'd0, 24'd0, 12'd0, 24'd0, 16'h0000, 16'($urandom));
        run_phase(51, 0, 200);

        configure(COUNT_TOP, COUNT_TOP, 12'd4095, COUNT_TOP, 16'h7FFF, 16'h8000);
        run_phase(0, 51, 200);

        configure(24'd12, 24'd12, 12'($urandom), 24'd5, 16'($urandom), 16'($urandom));
        run_phase(7, 7, 250);

        // Back pressure: the receiver holds off while the sender keeps offering.
        configure(24'd4, 24'd6, 12'd1000, 24'd3, 16'($urandom), 16'($urandom));
        pressure_on = 1'b1;
        run_phase(0, 0, 270);
        pressure_on = 1'b0;

        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
